// File: hdl/pdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types, codes and character constants of the printf directive
// formatter.
// ----------------------------------------------------------------------------
package pdf_pkg;

	localparam int MAX_WIDTH_DEF     = 64;
	localparam int MAX_PRECISION_DEF = 48;
	localparam int ARG_BITS_DEF      = 64;

	// digit positions of the conversion register; octal of 64 bits needs 22
	localparam int NIB   = 22;
	localparam int DIG_W = NIB * 4;

	// flag bit positions
	localparam int FL_LEFT  = 0;
	localparam int FL_PLUS  = 1;
	localparam int FL_SPACE = 2;
	localparam int FL_ZERO  = 3;
	localparam int FL_HASH  = 4;

	// length modifier codes
	localparam logic [2:0] LEN_PLAIN = 3'd0;
	localparam logic [2:0] LEN_HH    = 3'd1;
	localparam logic [2:0] LEN_H     = 3'd2;
	localparam logic [2:0] LEN_L     = 3'd3;
	localparam logic [2:0] LEN_LL    = 3'd4;
	localparam logic [2:0] LEN_Z     = 3'd5;
	localparam logic [2:0] LEN_T     = 3'd6;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_XL    = 8'h78;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	typedef struct packed {
		logic        load;
		base_t       base;
		logic [63:0] bin;
		logic [6:0]  nbits;
	} dig_cmd_t;

	typedef struct packed {
		logic       done;
		logic [4:0] nd;
		logic [3:0] top;
	} dig_sts_t;

	typedef struct packed {
		logic [6:0]  lead;
		logic [1:0]  npre;
		logic [15:0] pre;
		logic [6:0]  zeros;
		logic [4:0]  nd;
		logic [6:0]  trail;
		logic [6:0]  total;
		logic        upper;
	} emit_plan_t;

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else if (upper) begin
			ch = CH_A_UP + {4'd0, nib} - 8'd10;
		end else begin
			ch = CH_A_LO + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage

// File: hdl/pdf_digit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_digit_unit
// Shared digit register: binary to BCD by shift and add-3, octal and hex by
// direct regrouping, leading-zero strip by shifting, then digits popped from
// the top one nibble at a time.
// ----------------------------------------------------------------------------
module pdf_digit_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  pdf_pkg::dig_cmd_t cmd,
	input  logic             pop,
	output pdf_pkg::dig_sts_t sts
);

	typedef enum logic [3:0] {
		DU_IDLE = 4'b0001,
		DU_DAB  = 4'b0010,
		DU_NORM = 4'b0100,
		DU_HOLD = 4'b1000
	} du_state_t;

	du_state_t                  state_q;
	logic [pdf_pkg::DIG_W-1:0]  dig_q;
	logic [63:0]                bin_q;
	logic [6:0]                 cnt_q;
	logic [4:0]                 nd_q;
	logic [pdf_pkg::DIG_W-1:0]  dig_init;
	logic [pdf_pkg::DIG_W-1:0]  dig_adj;
	logic [65:0]                oct_src;
	logic [3:0]                 top_nib;

	always_comb begin
		oct_src  = {2'b00, cmd.bin};
		dig_init = '0;
		for (int i = 0; i < pdf_pkg::NIB; i++) begin
			if (cmd.base == pdf_pkg::BASE_OCT) begin
				dig_init[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
			end else if (i < 16) begin
				dig_init[4*i +: 4] = cmd.bin[4*i +: 4];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < pdf_pkg::NIB; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			end else begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4];
			end
		end
	end

	assign top_nib = dig_q[pdf_pkg::DIG_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DU_IDLE;
			cnt_q   <= '0;
			nd_q    <= '0;
		end else if (cmd.load) begin
			nd_q <= 5'(pdf_pkg::NIB);
			cnt_q <= cmd.nbits;
			if (cmd.base == pdf_pkg::BASE_DEC) begin
				state_q <= DU_DAB;
			end else begin
				state_q <= DU_NORM;
			end
		end else begin
			case (state_q)
				DU_DAB: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= DU_NORM;
					end
				end
				DU_NORM: begin
					if (top_nib == 4'd0 && nd_q > 5'd1) begin
						nd_q <= nd_q - 5'd1;
					end else begin
						state_q <= DU_HOLD;
					end
				end
				DU_HOLD, DU_IDLE: begin
					state_q <= state_q;
				end
				default: begin
					state_q <= DU_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= cmd.bin << (7'd64 - cmd.nbits);
			if (cmd.base == pdf_pkg::BASE_DEC) begin
				dig_q <= '0;
			end else begin
				dig_q <= dig_init;
			end
		end else if (state_q == DU_DAB) begin
			dig_q <= {dig_adj[pdf_pkg::DIG_W-2:0], bin_q[63]};
			bin_q <= {bin_q[62:0], 1'b0};
		end else if ((state_q == DU_NORM && top_nib == 4'd0 && nd_q > 5'd1) ||
				(state_q == DU_HOLD && pop)) begin
			dig_q <= {dig_q[pdf_pkg::DIG_W-5:0], 4'd0};
		end
	end

	assign sts.done = (state_q == DU_HOLD);
	assign sts.nd   = nd_q;
	assign sts.top  = top_nib;

endmodule

// File: hdl/pdf_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_emitter
// Character sequencer: leading spaces, prefix, zero fill, digits, trailing
// spaces, one character per beat into the output register.
// ----------------------------------------------------------------------------
module pdf_emitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pdf_pkg::emit_plan_t plan,
	input  logic [3:0]         dig_nib,
	output logic               pop,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               last
);

	logic [6:0]  lead_q;
	logic [1:0]  npre_q;
	logic [15:0] pre_q;
	logic [6:0]  zero_q;
	logic [4:0]  nd_q;
	logic [6:0]  trail_q;
	logic [6:0]  tot_q;
	logic        upper_q;
	logic        ov_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        adv;
	logic [7:0]  ch;

	assign adv  = (tot_q != 7'd0) && (!ov_q || out_ready);
	assign busy = (tot_q != 7'd0);

	always_comb begin
		if (lead_q != 7'd0) begin
			ch = pdf_pkg::CH_SPACE;
		end else if (npre_q != 2'd0) begin
			ch = pre_q[15:8];
		end else if (zero_q != 7'd0) begin
			ch = pdf_pkg::CH_ZERO;
		end else if (nd_q != 5'd0) begin
			ch = pdf_pkg::digit_char(dig_nib, upper_q);
		end else begin
			ch = pdf_pkg::CH_SPACE;
		end
	end

	assign pop = adv && lead_q == 7'd0 && npre_q == 2'd0 && zero_q == 7'd0 && nd_q != 5'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			npre_q  <= '0;
			zero_q  <= '0;
			nd_q    <= '0;
			trail_q <= '0;
			tot_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				lead_q  <= plan.lead;
				npre_q  <= plan.npre;
				zero_q  <= plan.zeros;
				nd_q    <= plan.nd;
				trail_q <= plan.trail;
				tot_q   <= plan.total;
			end else if (adv) begin
				tot_q <= tot_q - 7'd1;
				if (lead_q != 7'd0) begin
					lead_q <= lead_q - 7'd1;
				end else if (npre_q != 2'd0) begin
					npre_q <= npre_q - 2'd1;
				end else if (zero_q != 7'd0) begin
					zero_q <= zero_q - 7'd1;
				end else if (nd_q != 5'd0) begin
					nd_q <= nd_q - 5'd1;
				end else begin
					trail_q <= trail_q - 7'd1;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pre_q   <= plan.pre;
			upper_q <= plan.upper;
		end else if (adv && lead_q == 7'd0 && npre_q != 2'd0) begin
			pre_q <= {pre_q[7:0], 8'd0};
		end
		if (adv) begin
			char_q <= ch;
			last_q <= (tot_q == 7'd1);
		end
	end

	assign out_valid = ov_q;
	assign out_char  = char_q;
	assign last      = last_q;

endmodule

// File: hdl/printf_directive_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_directive_formatter_unit
// Formats one parsed printf integer directive into a stream of characters.
// ----------------------------------------------------------------------------
// One directive is taken at a time; in_ready is high only while the unit is
// idle. A decimal conversion runs every bit of the truncated argument (8, 16,
// 32 or up to 64) through the shift-and-add-3 digit unit, octal and hex load
// their digits directly; then the digit register strips leading zeros at one
// digit a cycle, a plan state computes the padding, and the characters leave
// at one per cycle while out_ready is high. %c, %% and unknown bytes go
// straight to the plan state. A NUL conversion is accepted and gives no
// characters. The next directive is accepted while the last character still
// waits in the output register.
// ----------------------------------------------------------------------------
module printf_directive_formatter_unit #(
	parameter int MAX_WIDTH     = pdf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_PRECISION = pdf_pkg::MAX_PRECISION_DEF,
	parameter int ARG_BITS      = pdf_pkg::ARG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        long_is_wide,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  conv_char,
	input  logic [4:0]  flag_bits,
	input  logic signed [7:0] field_width,
	input  logic signed [6:0] precision,
	input  logic [2:0]  length_mod,
	input  logic [63:0] arg_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_PLAN = 4'b0100,
		ST_EMIT = 4'b1000
	} st_t;

	st_t                 state_q;
	logic                long_q;
	logic                numeric_q;
	logic                left_q;
	logic                zflag_q;
	logic                has_prec_q;
	logic [5:0]          prec_q;
	logic [6:0]          width_q;
	logic [1:0]          npre_q;
	logic [15:0]         pre_q;
	logic                upper_q;
	logic                pad_ok_q;

	logic                accept;
	logic [6:0]          nbits;
	logic [63:0]         mask;
	logic [63:0]         pmask;
	logic [63:0]         sv;
	logic                neg;
	logic [63:0]         mag;
	logic [7:0]          wmag;
	logic                wneg;
	logic                left;
	logic [6:0]          width;
	logic                has_prec;
	logic [5:0]          prec;
	logic                numeric;
	logic                zflag;
	logic                pad_ok;
	logic [1:0]          npre;
	logic [15:0]         pre;
	logic                upper;
	logic [63:0]         uv;
	pdf_pkg::base_t      base;
	logic [6:0]          dnbits;

	pdf_pkg::dig_cmd_t   dcmd;
	pdf_pkg::dig_sts_t   dsts;
	pdf_pkg::emit_plan_t plan;
	logic                emit_load;
	logic                emit_busy;
	logic                pop;

	logic [6:0]          nd7;
	logic [6:0]          zeros;
	logic [6:0]          content;
	logic [6:0]          spaces;
	logic                zpad;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	always_comb begin
		case (length_mod)
			pdf_pkg::LEN_HH:               nbits = 7'd8;
			pdf_pkg::LEN_H:                nbits = 7'd16;
			pdf_pkg::LEN_L:                nbits = long_q ? 7'd64 : 7'd32;
			pdf_pkg::LEN_LL:               nbits = 7'd64;
			pdf_pkg::LEN_Z, pdf_pkg::LEN_T: nbits = 7'(ARG_BITS);
			default:                       nbits = 7'd32;
		endcase
		mask  = (nbits >= 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << nbits);
		pmask = (ARG_BITS >= 64) ? {64{1'b1}} : ~({64{1'b1}} << 7'(ARG_BITS));
		sv    = arg_value & mask;
		neg   = sv[6'(nbits - 7'd1)];
		mag   = neg ? ((~arg_value & mask) + 64'd1) : sv;
	end

	always_comb begin
		wneg     = field_width[7];
		wmag     = wneg ? 8'(8'd0 - field_width) : field_width;
		width    = (wmag > 8'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : wmag[6:0];
		left     = flag_bits[pdf_pkg::FL_LEFT] | wneg;
		has_prec = !precision[6];
		prec     = (precision[5:0] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision[5:0];

		numeric = 1'b0;
		zflag   = 1'b0;
		pad_ok  = 1'b0;
		npre    = 2'd0;
		pre     = 16'd0;
		upper   = 1'b0;
		uv      = sv;
		base    = pdf_pkg::BASE_DEC;
		dnbits  = nbits;
		case (conv_char)
			pdf_pkg::CH_D, pdf_pkg::CH_I: begin
				numeric = 1'b1;
				pad_ok  = 1'b1;
				uv      = mag;
				zflag   = flag_bits[pdf_pkg::FL_ZERO] && !has_prec;
				if (neg) begin
					npre = 2'd1;
					pre  = {pdf_pkg::CH_MINUS, 8'd0};
				end else if (flag_bits[pdf_pkg::FL_PLUS]) begin
					npre = 2'd1;
					pre  = {pdf_pkg::CH_PLUS, 8'd0};
				end else if (flag_bits[pdf_pkg::FL_SPACE]) begin
					npre = 2'd1;
					pre  = {pdf_pkg::CH_SPACE, 8'd0};
				end
			end
			pdf_pkg::CH_U: begin
				numeric = 1'b1;
				pad_ok  = 1'b1;
				zflag   = flag_bits[pdf_pkg::FL_ZERO] && !has_prec;
			end
			pdf_pkg::CH_O: begin
				numeric = 1'b1;
				pad_ok  = 1'b1;
				base    = pdf_pkg::BASE_OCT;
				zflag   = flag_bits[pdf_pkg::FL_ZERO] && !has_prec;
				if (flag_bits[pdf_pkg::FL_HASH] && sv != 64'd0) begin
					npre = 2'd1;
					pre  = {pdf_pkg::CH_ZERO, 8'd0};
				end
			end
			pdf_pkg::CH_XL, pdf_pkg::CH_XU: begin
				numeric = 1'b1;
				pad_ok  = 1'b1;
				base    = pdf_pkg::BASE_HEX;
				upper   = (conv_char == pdf_pkg::CH_XU);
				zflag   = flag_bits[pdf_pkg::FL_ZERO] && !has_prec;
				if (flag_bits[pdf_pkg::FL_HASH] && sv != 64'd0) begin
					npre = 2'd2;
					pre  = {pdf_pkg::CH_ZERO, conv_char};
				end
			end
			pdf_pkg::CH_P: begin
				numeric = 1'b1;
				pad_ok  = 1'b1;
				base    = pdf_pkg::BASE_HEX;
				uv      = arg_value & pmask;
				dnbits  = 7'(ARG_BITS);
				zflag   = flag_bits[pdf_pkg::FL_ZERO];
				npre    = 2'd2;
				pre     = {pdf_pkg::CH_ZERO, pdf_pkg::CH_XL};
			end
			pdf_pkg::CH_C: begin
				pad_ok = 1'b1;
				npre   = 2'd1;
				pre    = {arg_value[7:0], 8'd0};
			end
			pdf_pkg::CH_PCT: begin
				npre = 2'd1;
				pre  = {pdf_pkg::CH_PCT, 8'd0};
			end
			default: begin
				npre = 2'd2;
				pre  = {pdf_pkg::CH_PCT, conv_char};
			end
		endcase
	end

	assign dcmd.load  = accept && numeric;
	assign dcmd.base  = base;
	assign dcmd.bin   = uv;
	assign dcmd.nbits = dnbits;

	pdf_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.pop    (pop),
		.sts    (dsts)
	);

	always_comb begin
		nd7     = numeric_q ? {2'b00, dsts.nd} : 7'd0;
		zeros   = (numeric_q && has_prec_q && {1'b0, prec_q} > nd7) ?
			({1'b0, prec_q} - nd7) : 7'd0;
		content = {5'd0, npre_q} + zeros + nd7;
		spaces  = (pad_ok_q && width_q > content) ? (width_q - content) : 7'd0;
		zpad    = !left_q && zflag_q;

		plan.lead  = (!left_q && !zpad) ? spaces : 7'd0;
		plan.npre  = npre_q;
		plan.pre   = pre_q;
		plan.zeros = zeros + (zpad ? spaces : 7'd0);
		plan.nd    = nd7[4:0];
		plan.trail = left_q ? spaces : 7'd0;
		plan.total = content + spaces;
		plan.upper = upper_q;
	end

	assign emit_load = (state_q == ST_PLAN);

	pdf_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.plan      (plan),
		.dig_nib   (dsts.top),
		.pop       (pop),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			long_q  <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				long_q <= long_is_wide;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && conv_char != pdf_pkg::CH_NUL) begin
						state_q <= numeric ? ST_CONV : ST_PLAN;
					end
				end
				ST_CONV: begin
					if (dsts.done) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			numeric_q  <= numeric;
			left_q     <= left;
			zflag_q    <= zflag;
			has_prec_q <= has_prec;
			prec_q     <= prec;
			width_q    <= width;
			npre_q     <= npre;
			pre_q      <= pre;
			upper_q    <= upper;
			pad_ok_q   <= pad_ok;
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the printf directive formatter. Each accepted
// directive is formatted by a behavioral predictor into the characters it
// must produce; every output beat is compared in order against them. A short
// directed set covers the conversions and corner cases, then random
// directives run under several idle and stall patterns and both settings of
// the long-width register.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          CYCLE_LIMIT  = 1_000_000;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          MAX_CHARS    = 64;
	localparam int          NO_PREC      = -1;
	localparam logic [2:0]  LEN_SPARE    = 3'd7;
	localparam logic [7:0]  CH_S         = 8'h73;
	localparam logic [7:0]  CH_HIGH      = 8'hFF;
	localparam logic [4:0]  F_LEFT       = 5'b1 << pdf_pkg::FL_LEFT;
	localparam logic [4:0]  F_PLUS       = 5'b1 << pdf_pkg::FL_PLUS;
	localparam logic [4:0]  F_SPACE      = 5'b1 << pdf_pkg::FL_SPACE;
	localparam logic [4:0]  F_ZERO       = 5'b1 << pdf_pkg::FL_ZERO;
	localparam logic [4:0]  F_HASH       = 5'b1 << pdf_pkg::FL_HASH;
	localparam logic [4:0]  F_ALL        = F_LEFT | F_PLUS | F_SPACE | F_ZERO | F_HASH;

	typedef struct {
		logic [7:0]        conv;
		logic [4:0]        flags;
		logic signed [7:0] width;
		logic signed [6:0] prec;
		logic [2:0]        lmod;
		logic [63:0]       arg;
	} directive_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		int         item;
	} text_beat_t;

	class char_scoreboard;
		logic       long_wide = 1'b1;
		int         errors;
		int         directives;
		text_beat_t expected_text[$];

		function int pending();
			return expected_text.size();
		endfunction

		function void set_long_wide(logic v);
			long_wide = v;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 100) $display("%0t ns mismatch: %s", $time, msg);
		endtask

		function int unsigned len_bits(logic [2:0] lm);
			case (lm)
				pdf_pkg::LEN_HH:                return 8;
				pdf_pkg::LEN_H:                 return 16;
				pdf_pkg::LEN_L:                 return long_wide ? 64 : 32;
				pdf_pkg::LEN_LL:                return 64;
				pdf_pkg::LEN_Z, pdf_pkg::LEN_T: return pdf_pkg::ARG_BITS_DEF;
				default:                        return 32;
			endcase
		endfunction

		function logic [63:0] low_mask(int unsigned nbits);
			return nbits >= 64 ? '1 : ((64'd1 << nbits) - 64'd1);
		endfunction

		function void note_directive(directive_t d);
			logic [7:0]  text[$];
			logic [7:0]  pre[$];
			logic [7:0]  digs[$];
			logic [4:0]  fl;
			logic [63:0] m, v, uv;
			int unsigned nbits, base, k;
			int          w, p, zeros, content, spaces, pad;
			bit          has_prec, zpad, numeric;
			string       tab;
			text_beat_t  b;
			fl = d.flags;
			w = d.width;
			if (w < 0) begin
				fl[pdf_pkg::FL_LEFT] = 1'b1;
				w = -w;
			end
			if (w > pdf_pkg::MAX_WIDTH_DEF) w = pdf_pkg::MAX_WIDTH_DEF;
			p = d.prec;
			has_prec = p >= 0;
			if (p > pdf_pkg::MAX_PRECISION_DEF) p = pdf_pkg::MAX_PRECISION_DEF;
			base = 10;
			tab = "0123456789abcdef";
			uv = '0;
			numeric = 1'b1;
			directives++;
			case (d.conv)
				pdf_pkg::CH_NUL: return;
				pdf_pkg::CH_D, pdf_pkg::CH_I: begin
					nbits = len_bits(d.lmod);
					m = low_mask(nbits);
					v = d.arg & m;
					if (v[nbits-1]) begin
						v = v | ~m;
						uv = -v;
						pre.push_back(pdf_pkg::CH_MINUS);
					end else begin
						uv = v;
						if (fl[pdf_pkg::FL_PLUS]) pre.push_back(pdf_pkg::CH_PLUS);
						else if (fl[pdf_pkg::FL_SPACE]) pre.push_back(pdf_pkg::CH_SPACE);
					end
					if (has_prec) fl[pdf_pkg::FL_ZERO] = 1'b0;
				end
				pdf_pkg::CH_U, pdf_pkg::CH_O, pdf_pkg::CH_XL, pdf_pkg::CH_XU: begin
					uv = d.arg & low_mask(len_bits(d.lmod));
					base = d.conv == pdf_pkg::CH_O ? 8 : d.conv == pdf_pkg::CH_U ? 10 : 16;
					if (d.conv == pdf_pkg::CH_XU) tab = "0123456789ABCDEF";
					if (fl[pdf_pkg::FL_HASH] && uv != 0) begin
						if (d.conv == pdf_pkg::CH_O) begin
							pre.push_back(pdf_pkg::CH_ZERO);
						end else if (d.conv != pdf_pkg::CH_U) begin
							pre.push_back(pdf_pkg::CH_ZERO);
							pre.push_back(d.conv);
						end
					end
					if (has_prec) fl[pdf_pkg::FL_ZERO] = 1'b0;
				end
				pdf_pkg::CH_P: begin
					uv = d.arg & low_mask(pdf_pkg::ARG_BITS_DEF);
					base = 16;
					pre.push_back(pdf_pkg::CH_ZERO);
					pre.push_back(pdf_pkg::CH_XL);
				end
				pdf_pkg::CH_C: begin
					numeric = 1'b0;
					pad = w > 1 ? w - 1 : 0;
					if (!fl[pdf_pkg::FL_LEFT]) repeat (pad) text.push_back(pdf_pkg::CH_SPACE);
					text.push_back(d.arg[7:0]);
					if (fl[pdf_pkg::FL_LEFT]) repeat (pad) text.push_back(pdf_pkg::CH_SPACE);
				end
				pdf_pkg::CH_PCT: begin
					numeric = 1'b0;
					text.push_back(pdf_pkg::CH_PCT);
				end
				default: begin
					numeric = 1'b0;
					text.push_back(pdf_pkg::CH_PCT);
					text.push_back(d.conv);
				end
			endcase
			if (numeric) begin
				if (uv == 0) digs.push_front(pdf_pkg::CH_ZERO);
				while (uv != 0) begin
					k = 32'(uv % base);
					digs.push_front(tab[k]);
					uv = uv / base;
				end
				zeros = (has_prec && p > digs.size()) ? p - digs.size() : 0;
				content = pre.size() + zeros + digs.size();
				spaces = w > content ? w - content : 0;
				zpad = !fl[pdf_pkg::FL_LEFT] && fl[pdf_pkg::FL_ZERO];
				if (!fl[pdf_pkg::FL_LEFT] && !zpad)
					repeat (spaces) text.push_back(pdf_pkg::CH_SPACE);
				foreach (pre[i]) text.push_back(pre[i]);
				repeat (zeros + (zpad ? spaces : 0)) text.push_back(pdf_pkg::CH_ZERO);
				foreach (digs[i]) text.push_back(digs[i]);
				if (fl[pdf_pkg::FL_LEFT]) repeat (spaces) text.push_back(pdf_pkg::CH_SPACE);
			end
			while (text.size() > MAX_CHARS) void'(text.pop_back());
			foreach (text[i]) begin
				b.ch = text[i];
				b.last = (i == text.size() - 1);
				b.item = directives;
				expected_text.push_back(b);
			end
		endfunction

		task check_char(logic [7:0] ch, logic lst);
			text_beat_t e;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b", ch, lst));
				return;
			end
			e = expected_text.pop_front();
			if (ch !== e.ch || lst !== e.last)
				report_mismatch($sformatf("directive %0d: char %h last %b, want %h last %b",
					e.item, ch, lst, e.ch, e.last));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              long_is_wide;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        conv_char;
	logic [4:0]        flag_bits;
	logic signed [7:0] field_width;
	logic signed [6:0] precision;
	logic [2:0]        length_mod;
	logic [63:0]       arg_value;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        out_char;
	logic              last;

	char_scoreboard sb;
	int             in_idle_pct;
	int             out_stall_pct;
	int             cycle_count;

	printf_directive_formatter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.long_is_wide (long_is_wide),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.conv_char    (conv_char),
		.flag_bits    (flag_bits),
		.field_width  (field_width),
		.precision    (precision),
		.length_mod   (length_mod),
		.arg_value    (arg_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_char(out_char, last);
	end

	function automatic directive_t make_directive(logic [7:0] c, logic [4:0] f, int w, int p,
			logic [2:0] lm, logic [63:0] a);
		directive_t d;
		d.conv = c;
		d.flags = f;
		d.width = 8'(w);
		d.prec = 7'(p);
		d.lmod = lm;
		d.arg = a;
		return d;
	endfunction

	function automatic directive_t random_directive();
		directive_t d;
		int         sel;
		sel = $urandom_range(99);
		if (sel < 85) begin
			case ($urandom_range(8))
				0: d.conv = pdf_pkg::CH_D;
				1: d.conv = pdf_pkg::CH_I;
				2: d.conv = pdf_pkg::CH_U;
				3: d.conv = pdf_pkg::CH_O;
				4: d.conv = pdf_pkg::CH_XL;
				5: d.conv = pdf_pkg::CH_XU;
				6: d.conv = pdf_pkg::CH_P;
				7: d.conv = pdf_pkg::CH_C;
				default: d.conv = pdf_pkg::CH_PCT;
			endcase
		end else if (sel < 97) begin
			d.conv = 8'($urandom);
		end else begin
			d.conv = pdf_pkg::CH_NUL;
		end
		d.flags = 5'($urandom);
		if ($urandom_range(9) == 0) d.width = 8'($urandom);
		else d.width = 8'($urandom_range(40) - 20);
		case ($urandom_range(3))
			0: d.prec = 7'($urandom);
			1: d.prec = 7'($urandom_range(64, 127));
			default: d.prec = 7'($urandom_range(24));
		endcase
		d.lmod = 3'($urandom);
		case ($urandom_range(5))
			0: d.arg = '0;
			1: d.arg = 64'($urandom_range(999));
			2: d.arg = {$urandom, $urandom};
			3: d.arg = -64'($urandom_range(1, 999));
			4: d.arg = 64'd1 << $urandom_range(63);
			default: d.arg = {$urandom, $urandom} >> $urandom_range(63);
		endcase
		return d;
	endfunction

	task automatic send_directive(directive_t d);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		conv_char <= d.conv;
		flag_bits <= d.flags;
		field_width <= d.width;
		precision <= d.prec;
		length_mod <= d.lmod;
		arg_value <= d.arg;
		do @(posedge clk); while (!in_ready);
		sb.note_directive(d);
		@(negedge clk);
	endtask

	task automatic write_long_wide(logic v);
		cfg_valid <= 1'b1;
		long_is_wide <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_long_wide(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random_phase(int n, int idle_pct, int stall_pct, logic wide);
		write_long_wide(wide);
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		repeat (n) send_directive(random_directive());
		drain();
	endtask

	initial begin
		sb = new;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		long_is_wide = 1'b1;
		in_valid = 1'b0;
		conv_char = pdf_pkg::CH_NUL;
		flag_bits = '0;
		field_width = '0;
		precision = '0;
		length_mod = pdf_pkg::LEN_PLAIN;
		arg_value = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_long_wide(1'b1);
		send_directive(make_directive(pdf_pkg::CH_D, '0, 0, NO_PREC, pdf_pkg::LEN_PLAIN, '0));
		send_directive(make_directive(pdf_pkg::CH_D, '0, 0, 0, pdf_pkg::LEN_PLAIN, '0));
		send_directive(make_directive(pdf_pkg::CH_D, F_PLUS, 10, NO_PREC, pdf_pkg::LEN_PLAIN,
			64'hFFFF_FFFF_8000_0000));
		send_directive(make_directive(pdf_pkg::CH_I, F_SPACE | F_ZERO, 12, NO_PREC,
			pdf_pkg::LEN_LL, 64'd42));
		send_directive(make_directive(pdf_pkg::CH_D, F_PLUS, -12, 5, pdf_pkg::LEN_HH, 64'h7F));
		send_directive(make_directive(pdf_pkg::CH_I, F_PLUS, 0, NO_PREC, pdf_pkg::LEN_LL,
			64'h8000_0000_0000_0000));
		send_directive(make_directive(pdf_pkg::CH_D, F_ZERO, 20, 4, pdf_pkg::LEN_H,
			64'h1234_8001));
		send_directive(make_directive(pdf_pkg::CH_U, F_HASH | F_PLUS, 8, NO_PREC,
			pdf_pkg::LEN_L, '1));
		send_directive(make_directive(pdf_pkg::CH_O, F_HASH, 0, NO_PREC, pdf_pkg::LEN_LL, '1));
		send_directive(make_directive(pdf_pkg::CH_O, F_HASH, 5, NO_PREC, pdf_pkg::LEN_PLAIN,
			'0));
		send_directive(make_directive(pdf_pkg::CH_XL, F_HASH | F_ZERO, 16, NO_PREC,
			pdf_pkg::LEN_Z, 64'hDEAD_BEEF));
		send_directive(make_directive(pdf_pkg::CH_XU, F_HASH, -20, 10, pdf_pkg::LEN_T,
			64'hABCD));
		send_directive(make_directive(pdf_pkg::CH_XL, F_HASH, 0, 0, pdf_pkg::LEN_PLAIN, '0));
		send_directive(make_directive(pdf_pkg::CH_P, F_ZERO, 24, 30, pdf_pkg::LEN_PLAIN,
			64'h1234));
		send_directive(make_directive(pdf_pkg::CH_P, F_LEFT | F_ZERO, 30, NO_PREC,
			pdf_pkg::LEN_PLAIN, '0));
		send_directive(make_directive(pdf_pkg::CH_U, '0, 0, 63, LEN_SPARE, 64'h1_0000_0001));
		send_directive(make_directive(pdf_pkg::CH_C, F_ZERO | F_PLUS, 5, 3, pdf_pkg::LEN_PLAIN,
			64'h141));
		send_directive(make_directive(pdf_pkg::CH_C, '0, -64, NO_PREC, pdf_pkg::LEN_PLAIN,
			64'h7E));
		send_directive(make_directive(pdf_pkg::CH_PCT, F_ZERO | F_LEFT, 30, 5,
			pdf_pkg::LEN_PLAIN, '0));
		send_directive(make_directive(CH_S, '0, 10, NO_PREC, pdf_pkg::LEN_PLAIN, 64'h55));
		send_directive(make_directive(CH_HIGH, F_ALL, 127, -64, LEN_SPARE, '1));
		send_directive(make_directive(pdf_pkg::CH_NUL, F_ALL, -1, 0, pdf_pkg::LEN_LL, '1));
		send_directive(make_directive(pdf_pkg::CH_D, F_ZERO, 100, NO_PREC, pdf_pkg::LEN_HH,
			64'h80));
		send_directive(make_directive(pdf_pkg::CH_XL, F_LEFT, -128, 48, pdf_pkg::LEN_LL, '1));
		send_directive(make_directive(pdf_pkg::CH_O, '0, 127, -64, pdf_pkg::LEN_H, 64'hFFFF));
		drain();

		run_random_phase(112, 0, 0, 1'b0);
		run_random_phase(112, 73, 0, 1'b1);
		run_random_phase(113, 0, 73, 1'b0);
		run_random_phase(113, 28, 28, 1'b1);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/pdf_pkg.sv
hdl/pdf_digit_unit.sv
hdl/pdf_emitter.sv
hdl/printf_directive_formatter_unit.sv
verif/testbench.sv
